// File: design/assert_macros.svh
// Assertion macros for the filter's RTL files, included by nabf_ctrl.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: design/nabf_pkg.sv
// Shared types and constants of the neighbor average blend filter.
// No dependencies; imported by the controller, the datapath and the top level.
package nabf_pkg;

	localparam int CH_W   = 16;
	localparam int PX_W   = 3 * CH_W;
	localparam int SUM_W  = CH_W + 3;
	localparam int CFG_W  = 11;
	localparam int NB_NUM = 4;

	// Reciprocal of three, scaled by 2**RECIP3_SHIFT; exact for inputs below 2**19.
	localparam int              RECIP3_SHIFT = 19;
	localparam logic [17:0]     RECIP3       = 18'd174763;
	localparam int              PROD_W       = 36;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

	// Configuration register indexes.
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// Item modes.
	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	// Neighbor slots.
	localparam int NB_UP    = 0;
	localparam int NB_DOWN  = 1;
	localparam int NB_LEFT  = 2;
	localparam int NB_RIGHT = 3;

	typedef struct packed {
		logic              load_px;
		logic              write_cur;
		logic              cap_left;
		logic              cap_ctr;
		logic              cap_sum;
		logic              load_out;
		logic              rotate;
		logic [NB_NUM-1:0] have;
		logic              eof;
	} nabf_cmd_t;

endpackage

// File: design/nabf_dp.sv
// Datapath of the filter: three rotating row buffers, neighbor window, blend and divide.
// Depends on nabf_pkg; driven by nabf_ctrl through nabf_cmd_t.
module nabf_dp #(
	parameter int MAX_WIDTH = 1024,
	parameter int COL_W     = $clog2(MAX_WIDTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nabf_pkg::nabf_cmd_t           cmd,
	input  logic [COL_W-1:0]              waddr,
	input  logic [COL_W-1:0]              raddr,
	input  logic [nabf_pkg::CH_W-1:0]     in_red,
	input  logic [nabf_pkg::CH_W-1:0]     in_green,
	input  logic [nabf_pkg::CH_W-1:0]     in_blue,
	output logic [nabf_pkg::CH_W-1:0]     out_red,
	output logic [nabf_pkg::CH_W-1:0]     out_green,
	output logic [nabf_pkg::CH_W-1:0]     out_blue,
	output logic                          end_of_frame
);
	import nabf_pkg::*;

	function automatic logic [CH_W-1:0] chan(input logic [PX_W-1:0] px, input int k);
		return px[PX_W-1-CH_W*k -: CH_W];
	endfunction

	logic [1:0]      rot_q;
	logic [1:0]      cur_bank, prev_bank, older_bank;
	logic [PX_W-1:0] bank_rd [3];
	logic [PX_W-1:0] px_q, left_q, ctr_q, up_q;
	logic [SUM_W-1:0] sum_q [3];
	logic [SUM_W-1:0] sum_d [3];
	logic [CH_W-1:0]  res_d [3];
	logic [CH_W-1:0]  out_q [3];
	logic             eof_q;
	logic [2:0]       nb_count;

	assign cur_bank   = rot_q;
	assign prev_bank  = (rot_q == 2'd0) ? 2'd2 : rot_q - 2'd1;
	assign older_bank = (rot_q == 2'd2) ? 2'd0 : rot_q + 2'd1;

	// Rotate roles at a row end: older takes previous, previous takes current.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q <= 2'd0;
		end else if (cmd.rotate) begin
			rot_q <= (rot_q == 2'd2) ? 2'd0 : rot_q + 2'd1;
		end
	end

	for (genvar b = 0; b < 3; b++) begin : g_bank
		logic [PX_W-1:0] mem [MAX_WIDTH];
		logic [PX_W-1:0] rd_q;
		always_ff @(posedge clk) begin
			if (cmd.write_cur && cur_bank == 2'(b)) begin
				mem[waddr] <= px_q;
			end
			rd_q <= mem[raddr];
		end
		assign bank_rd[b] = rd_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_px) begin
			px_q <= {in_red, in_green, in_blue};
		end
		if (cmd.cap_left) begin
			left_q <= bank_rd[prev_bank];
		end
		if (cmd.cap_ctr) begin
			ctr_q <= bank_rd[prev_bank];
			up_q  <= bank_rd[older_bank];
		end
	end

	// Sum every present neighbor together with one copy of the center per neighbor.
	always_comb begin
		logic [PX_W-1:0] nb [NB_NUM];
		nb[NB_UP]    = up_q;
		nb[NB_DOWN]  = px_q;
		nb[NB_LEFT]  = left_q;
		nb[NB_RIGHT] = bank_rd[prev_bank];
		for (int k = 0; k < 3; k++) begin
			sum_d[k] = '0;
			for (int i = 0; i < NB_NUM; i++) begin
				if (cmd.have[i]) begin
					sum_d[k] = sum_d[k] + SUM_W'(chan(nb[i], k)) + SUM_W'(chan(ctr_q, k));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_sum) begin
			for (int k = 0; k < 3; k++) begin
				sum_q[k] <= sum_d[k];
			end
		end
	end

	assign nb_count = 3'($countones(cmd.have));

	// Divide by twice the neighbor count: shifts, and a reciprocal multiply for six.
	always_comb begin
		logic [PROD_W-1:0] prod;
		for (int k = 0; k < 3; k++) begin
			prod = PROD_W'(sum_q[k][SUM_W-1:1]) * PROD_W'(RECIP3);
			case (nb_count)
				3'd1:    res_d[k] = sum_q[k][CH_W:1];
				3'd2:    res_d[k] = sum_q[k][CH_W+1:2];
				3'd3:    res_d[k] = prod[RECIP3_SHIFT+CH_W-1:RECIP3_SHIFT];
				3'd4:    res_d[k] = sum_q[k][CH_W+2:3];
				default: res_d[k] = chan(ctr_q, k);
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			for (int k = 0; k < 3; k++) begin
				out_q[k] <= res_d[k];
			end
			eof_q <= cmd.eof;
		end
	end

	assign out_red      = out_q[0];
	assign out_green    = out_q[1];
	assign out_blue     = out_q[2];
	assign end_of_frame = eof_q;

endmodule

// File: design/nabf_ctrl.sv
// Controller of the filter: configuration, position counters, flush state and sequencer.
// Depends on nabf_pkg and assert_macros.svh; commands nabf_dp through nabf_cmd_t.
`include "assert_macros.svh"

module nabf_ctrl #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int COL_W      = $clog2(MAX_WIDTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [nabf_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	output logic                          out_valid,
	input  logic                          out_stall,
	output nabf_pkg::nabf_cmd_t           cmd,
	output logic [COL_W-1:0]              waddr,
	output logic [COL_W-1:0]              raddr
);
	import nabf_pkg::*;

	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WU_W  = $clog2(MAX_WIDTH + 1);
	localparam int HU_W  = $clog2(MAX_HEIGHT + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_L,
		S_RD_C,
		S_RD_R,
		S_SUM,
		S_DIV
	} state_t;

	state_t           state_q;
	logic [CFG_W-1:0] frame_width_q, frame_height_q;
	logic [WU_W-1:0]  used_w;
	logic [HU_W-1:0]  used_h;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             flush_pending_q, flush_q, gen_q, out_valid_q;
	logic             in_acc, row_end, last_row, out_free, leave;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (frame_width_q < CFG_W'(2)) begin
			used_w = WU_W'(2);
		end else if (int'(frame_width_q) > MAX_WIDTH) begin
			used_w = WU_W'(MAX_WIDTH);
		end else begin
			used_w = WU_W'(frame_width_q);
		end
		if (frame_height_q < CFG_W'(1)) begin
			used_h = HU_W'(1);
		end else if (int'(frame_height_q) > MAX_HEIGHT) begin
			used_h = HU_W'(MAX_HEIGHT);
		end else begin
			used_h = HU_W'(frame_height_q);
		end
	end

	assign row_end  = (int'(col_q) + 1) >= int'(used_w);
	assign last_row = (int'(row_q) + 1) >= int'(used_h);
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign leave    = (state_q == S_DIV) && (!gen_q || out_free);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			col_q           <= '0;
			row_q           <= '0;
			flush_pending_q <= 1'b0;
			flush_q         <= 1'b0;
			gen_q           <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (mode == MODE_FLUSH) begin
							if (flush_pending_q) begin
								flush_q <= 1'b1;
								gen_q   <= 1'b1;
								state_q <= S_RD_L;
							end
						end else if (!flush_pending_q) begin
							flush_q <= 1'b0;
							gen_q   <= (row_q != '0);
							state_q <= S_RD_L;
						end
					end
				end
				S_RD_L: state_q <= S_RD_C;
				S_RD_C: state_q <= S_RD_R;
				S_RD_R: state_q <= S_SUM;
				S_SUM:  state_q <= S_DIV;
				S_DIV: begin
					if (leave) begin
						state_q <= S_IDLE;
						if (!row_end) begin
							col_q <= col_q + COL_W'(1);
						end else begin
							col_q <= '0;
							if (flush_q) begin
								flush_pending_q <= 1'b0;
								row_q           <= '0;
							end else if (last_row) begin
								flush_pending_q <= 1'b1;
							end else begin
								row_q <= row_q + ROW_W'(1);
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd                = '0;
		cmd.load_px        = in_acc;
		cmd.write_cur      = (state_q == S_RD_L) && !flush_q;
		cmd.cap_left       = (state_q == S_RD_C);
		cmd.cap_ctr        = (state_q == S_RD_R);
		cmd.cap_sum        = (state_q == S_SUM);
		cmd.load_out       = (state_q == S_DIV) && gen_q && out_free;
		cmd.rotate         = leave && !flush_q && row_end;
		cmd.have[NB_UP]    = flush_q ? (row_q != '0) : (int'(row_q) >= 2);
		cmd.have[NB_DOWN]  = !flush_q;
		cmd.have[NB_LEFT]  = (col_q != '0);
		cmd.have[NB_RIGHT] = !row_end;
		cmd.eof            = flush_q && row_end;
	end

	assign waddr = col_q;

	always_comb begin
		case (state_q)
			S_RD_L:  raddr = col_q - COL_W'(1);
			S_RD_R:  raddr = col_q + COL_W'(1);
			default: raddr = col_q;
		endcase
	end

	`ASSERT_NEXT(a_drop_stays_idle, clk, arst_n, (state_q == S_IDLE) && in_valid && (mode == MODE_PIXEL) && flush_pending_q, state_q == S_IDLE, "pixel during flush was not dropped")
	`ASSERT_NEXT(a_rotate_col_zero, clk, arst_n, cmd.rotate, col_q == '0, "row end did not restart the column")
	`ASSERT_NEXT(a_eof_ends_flush, clk, arst_n, cmd.load_out && cmd.eof, !flush_pending_q && (row_q == '0), "frame end left flush state behind")
	`ASSERT_IMPL(a_result_from_div, clk, arst_n, $rose(out_valid_q), $past(state_q == S_DIV), "result appeared outside the divide step")

endmodule

// File: design/neighbor_average_blend_filter.sv
// Top level of the four-neighbor average blend filter.
// Depends on nabf_pkg, nabf_ctrl and nabf_dp.
//
// Takes RGB pixels (unsigned Q4.12 per channel) in raster order and returns each
// pixel blended half and half with the average of its in-frame up, down, left and
// right neighbors, rounded down. Results lag one row: the pixel beat at row r
// yields the result for row r-1 at the same column, and after the frame's last
// pixel one flush beat (mode high) per column drains the last row, the final one
// flagged with end_of_frame. Pixel beats sent while that drain is pending are
// dropped, and flush beats sent while none is pending are ignored; either is
// accepted and leaves the block idle. Every other accepted beat takes the block
// through its steps, with the input stalled until it is idle again: the accept
// step, three reads of the single-read-port previous-row buffer at columns c-1,
// c and c+1, one step to sum the neighbors and one to divide by twice the neighbor
// count; a stalled output holds the divide step only while its register is still full.
// The three row buffers rotate roles at each pixel row end, so no copy or clearing
// pass is needed after reset. Write frame_width (register 0, used as 2..MAX_WIDTH)
// and frame_height (register 1, used as 1..MAX_HEIGHT) only while the block is idle.
module neighbor_average_blend_filter #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [nabf_pkg::CFG_W-1:0]    cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic [nabf_pkg::CH_W-1:0]     in_red,
	input  logic [nabf_pkg::CH_W-1:0]     in_green,
	input  logic [nabf_pkg::CH_W-1:0]     in_blue,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [nabf_pkg::CH_W-1:0]     out_red,
	output logic [nabf_pkg::CH_W-1:0]     out_green,
	output logic [nabf_pkg::CH_W-1:0]     out_blue,
	output logic                          end_of_frame
);
	import nabf_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);

	nabf_cmd_t        cmd;
	logic [COL_W-1:0] waddr, raddr;

	// Sequence each beat, track row/column and flush state, own the output valid.
	nabf_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.COL_W      (COL_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.waddr     (waddr),
		.raddr     (raddr)
	);

	// Hold the row buffers, gather the neighbor window, blend and register the result.
	nabf_dp #(
		.MAX_WIDTH (MAX_WIDTH),
		.COL_W     (COL_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.waddr        (waddr),
		.raddr        (raddr),
		.in_red       (in_red),
		.in_green     (in_green),
		.in_blue      (in_blue),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.end_of_frame (end_of_frame)
	);

endmodule

// File: tb/neighbor_average_blend_filter_tb.sv
// Self-checking testbench for the four-neighbor average blend filter.
// Depends on nabf_pkg and neighbor_average_blend_filter; predicts every output
// pixel in-bench and compares results beat by beat.
`timescale 1ns / 100ps

module neighbor_average_blend_filter_tb;
	import nabf_pkg::*;

	localparam int MAX_W      = 1024;
	localparam int MAX_H      = 1024;
	localparam int ITEMS      = 1750;  // random pixel and flush beats in small frames
	localparam int SETTLE     = 16;    // quiet cycles before a register write
	localparam int TAIL       = 20;    // cycles to watch for stray results at the end
	localparam int HOLD_LEN   = 150;   // long receiver hold-off, in cycles
	localparam int QUIET_MAX  = 2000;  // cycles with no beat before giving up
	localparam int WIDE_FRAME = 6;     // frame number of the widest row

	typedef logic [PX_W-1:0] pixel_t;

	// One filtered pixel as it leaves the block.
	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            eof;
	} blend_t;

	typedef enum logic [2:0] {
		OP_BEAT,     // offer one input beat
		OP_CFG,      // write one register
		OP_PACE,     // change idle and stall rates
		OP_HOLDOFF,  // ask the receiver for a long hold-off
		OP_DRAIN     // wait until every expected pixel has come out
	} plan_kind_t;

	typedef struct packed {
		plan_kind_t      kind;
		logic            md;
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            idx;
		logic [CFG_W-1:0] data;
		logic [6:0]      idle_pct;
		logic [6:0]      stall_pct;
	} plan_op_t;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             cfg_we       = 1'b0;
	logic             cfg_index    = REG_FRAME_WIDTH;
	logic [CFG_W-1:0] cfg_data     = '0;
	logic             in_valid     = 1'b0;
	logic             in_stall;
	logic             mode         = MODE_PIXEL;
	logic [CH_W-1:0]  in_red       = '0;
	logic [CH_W-1:0]  in_green     = '0;
	logic [CH_W-1:0]  in_blue      = '0;
	logic             out_valid;
	logic             out_stall    = 1'b0;
	logic [CH_W-1:0]  out_red;
	logic [CH_W-1:0]  out_green;
	logic [CH_W-1:0]  out_blue;
	logic             end_of_frame;

	plan_op_t pixel_plan[$];       // stimulus, filled up front by the initial block
	blend_t   expected_pixels[$];  // predicted output pixels, oldest first

	logic        plan_busy   = 1'b1;
	logic        holdoff_req = 1'b0;
	logic [6:0]  stall_pct   = '0;
	int unsigned send_idle_pct = 0;
	int unsigned settle      = 0;
	int          quiet_cycles = 0;
	int          errors      = 0;

	// Shadow of the filter: three row copies, position, drain flag and registers.
	pixel_t           upper_row [MAX_W];
	pixel_t           mid_row   [MAX_W];
	pixel_t           fill_row  [MAX_W];
	int unsigned      row_idx    = 0;
	int unsigned      col_idx    = 0;
	bit               drain_pend = 1'b0;
	logic [CFG_W-1:0] width_reg  = WIDTH_RESET;
	logic [CFG_W-1:0] height_reg = HEIGHT_RESET;

	neighbor_average_blend_filter #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.in_red      (in_red),
		.in_green    (in_green),
		.in_blue     (in_blue),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.end_of_frame(end_of_frame)
	);

	always #2 clk = ~clk;

	// Clamp the register values to the sizes the block really uses.
	function automatic int unsigned used_cols(logic [CFG_W-1:0] v);
		if (v < 2) return 2;
		if (v > MAX_W) return MAX_W;
		return v;
	endfunction

	function automatic int unsigned used_rows(logic [CFG_W-1:0] v);
		if (v < 1) return 1;
		if (v > MAX_H) return MAX_H;
		return v;
	endfunction

	// Blend the center half and half with the mean of the present neighbors,
	// per channel, rounding down: (sum + n*center) / (2*n).
	function automatic blend_t blend_px(pixel_t ctr, pixel_t up, pixel_t dn, pixel_t lf,
			pixel_t rt, logic [NB_NUM-1:0] have, logic eof);
		pixel_t      nbv [NB_NUM];
		pixel_t      acc;
		int unsigned cnt;
		int unsigned sum;
		int unsigned cval;
		int          i;
		int          k;
		nbv[NB_UP]    = up;
		nbv[NB_DOWN]  = dn;
		nbv[NB_LEFT]  = lf;
		nbv[NB_RIGHT] = rt;
		cnt = 0;
		for (i = 0; i < NB_NUM; i++)
			if (have[i]) cnt++;
		for (k = 0; k < 3; k++) begin
			cval = ctr[PX_W-1-CH_W*k -: CH_W];
			sum = 0;
			for (i = 0; i < NB_NUM; i++)
				if (have[i]) sum += nbv[i][PX_W-1-CH_W*k -: CH_W];
			if (cnt == 0)
				acc[PX_W-1-CH_W*k -: CH_W] = CH_W'(cval);
			else
				acc[PX_W-1-CH_W*k -: CH_W] = CH_W'((sum + cnt * cval) / (2 * cnt));
		end
		return {acc, eof};
	endfunction

	// Advance the shadow filter by one accepted input beat and queue the
	// output pixel it releases, if any.
	task automatic predict_filter(logic md, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
			logic [CH_W-1:0] b);
		int unsigned       w;
		int unsigned       h;
		int unsigned       c;
		pixel_t            px;
		pixel_t            lf;
		pixel_t            rt;
		logic [NB_NUM-1:0] have;
		w = used_cols(width_reg);
		h = used_rows(height_reg);
		c = col_idx;
		lf = (c >= 1) ? mid_row[c-1] : '0;
		rt = (c + 1 < w) ? mid_row[c+1] : '0;
		have = '0;
		have[NB_LEFT]  = c >= 1;
		have[NB_RIGHT] = c + 1 < w;
		if (md == MODE_FLUSH) begin
			// Flush with nothing pending is ignored.
			if (drain_pend) begin
				// Last row lives in mid_row, the row above it in upper_row.
				have[NB_UP] = row_idx >= 1;
				expected_pixels.push_back(blend_px(mid_row[c], upper_row[c], '0, lf, rt,
					have, c + 1 >= w));
				if (c + 1 >= w) begin
					drain_pend = 1'b0;
					row_idx = 0;
					col_idx = 0;
				end else begin
					col_idx = c + 1;
				end
			end
		end else if (!drain_pend) begin
			// Pixels offered while the last row drains are dropped.
			px = {r, g, b};
			fill_row[c] = px;
			if (row_idx >= 1) begin
				have[NB_UP]   = row_idx >= 2;
				have[NB_DOWN] = 1'b1;
				expected_pixels.push_back(blend_px(mid_row[c], upper_row[c], px, lf, rt,
					have, 1'b0));
			end
			if (c + 1 >= w) begin
				upper_row = mid_row;
				mid_row = fill_row;
				col_idx = 0;
				if (row_idx + 1 >= h)
					drain_pend = 1'b1;
				else
					row_idx++;
			end else begin
				col_idx = c + 1;
			end
		end
	endtask

	task automatic compare_field(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	function automatic logic [CH_W-1:0] rand_chan();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return CH_W'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic add_beat(logic md, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
			logic [CH_W-1:0] b);
		plan_op_t op;
		op = '0;
		op.kind  = OP_BEAT;
		op.md    = md;
		op.red   = r;
		op.green = g;
		op.blue  = b;
		pixel_plan.push_back(op);
	endtask

	// Register writes only land on an idle block: drain first.
	task automatic add_cfg(logic idx, logic [CFG_W-1:0] data);
		plan_op_t op;
		op = '0;
		op.kind = OP_DRAIN;
		pixel_plan.push_back(op);
		op.kind = OP_CFG;
		op.idx  = idx;
		op.data = data;
		pixel_plan.push_back(op);
	endtask

	// Idling phases: none, sender idle, receiver stalling, both.
	task automatic add_pace(int unsigned phase);
		plan_op_t op;
		op = '0;
		op.kind = OP_PACE;
		case (phase % 4)
			0: begin op.idle_pct = 0;  op.stall_pct = 0;  end
			1: begin op.idle_pct = 67; op.stall_pct = 0;  end
			2: begin op.idle_pct = 0;  op.stall_pct = 67; end
			default: begin op.idle_pct = 26; op.stall_pct = 26; end
		endcase
		pixel_plan.push_back(op);
	endtask

	// One full frame with random content, sprinkled with beats the block ignores.
	task automatic add_frame(logic [CFG_W-1:0] w_cfg, logic [CFG_W-1:0] h_cfg, bit new_cfg,
			int unsigned phase, bit hold, output int unsigned beats);
		int unsigned w;
		int unsigned h;
		int unsigned n;
		plan_op_t    op;
		w = used_cols(w_cfg);
		h = used_rows(h_cfg);
		if (new_cfg) begin
			add_cfg(REG_FRAME_WIDTH, w_cfg);
			add_cfg(REG_FRAME_HEIGHT, h_cfg);
		end
		add_pace(phase);
		if (hold) begin
			op = '0;
			op.kind = OP_HOLDOFF;
			pixel_plan.push_back(op);
		end
		for (n = 0; n < w * h; n++) begin
			// stray flush while no drain is pending
			if ($urandom_range(0, 24) == 0)
				add_beat(MODE_FLUSH, rand_chan(), rand_chan(), rand_chan());
			add_beat(MODE_PIXEL, rand_chan(), rand_chan(), rand_chan());
		end
		for (n = 0; n < w; n++) begin
			// pixel that lands during the drain and must be dropped
			if ($urandom_range(0, 7) == 0)
				add_beat(MODE_PIXEL, rand_chan(), rand_chan(), rand_chan());
			add_beat(MODE_FLUSH, rand_chan(), rand_chan(), rand_chan());
		end
		beats = w * h + w;
	endtask

	// Sender: present one beat at a time from the plan, predict each beat as it
	// is accepted, and carry out writes, pace changes and drains in plan order.
	always @(posedge clk or negedge arst_n) begin : sender
		plan_op_t op;
		logic     nxt_valid;
		logic     nxt_we;
		logic     nxt_hold;
		if (!arst_n) begin
			in_valid    <= 1'b0;
			mode        <= MODE_PIXEL;
			in_red      <= '0;
			in_green    <= '0;
			in_blue     <= '0;
			cfg_we      <= 1'b0;
			cfg_index   <= REG_FRAME_WIDTH;
			cfg_data    <= '0;
			holdoff_req <= 1'b0;
			stall_pct   <= '0;
			plan_busy   <= 1'b1;
			send_idle_pct = 0;
			settle = 0;
		end else begin
			nxt_valid = in_valid;
			nxt_we = 1'b0;
			nxt_hold = 1'b0;
			if (in_valid && !in_stall) begin
				predict_filter(mode, in_red, in_green, in_blue);
				nxt_valid = 1'b0;
			end
			// A stalled beat keeps nxt_valid high: hold it and its payload.
			if (!nxt_valid && pixel_plan.size() != 0) begin
				op = pixel_plan[0];
				case (op.kind)
					OP_BEAT: begin
						if ($urandom_range(0, 99) >= send_idle_pct) begin
							mode     <= op.md;
							in_red   <= op.red;
							in_green <= op.green;
							in_blue  <= op.blue;
							nxt_valid = 1'b1;
							pixel_plan.delete(0);
						end
					end
					OP_CFG: begin
						cfg_index <= op.idx;
						cfg_data  <= op.data;
						nxt_we = 1'b1;
						if (op.idx == REG_FRAME_WIDTH)
							width_reg = op.data;
						else
							height_reg = op.data;
						pixel_plan.delete(0);
					end
					OP_PACE: begin
						send_idle_pct = op.idle_pct;
						stall_pct <= op.stall_pct;
						pixel_plan.delete(0);
					end
					OP_HOLDOFF: begin
						nxt_hold = 1'b1;
						pixel_plan.delete(0);
					end
					default: begin
						// Drain: wait for the last expected pixel, then let any
						// no-result beat still in the block finish.
						if (expected_pixels.size() != 0) begin
							settle = 0;
						end else if (settle >= SETTLE) begin
							settle = 0;
							pixel_plan.delete(0);
						end else begin
							settle++;
						end
					end
				endcase
			end
			in_valid    <= nxt_valid;
			cfg_we      <= nxt_we;
			holdoff_req <= nxt_hold;
			plan_busy   <= (pixel_plan.size() != 0) || nxt_valid;
		end
	end

	// Receiver: check each accepted result against the oldest prediction and
	// drive the stall, either at random or for a long counted hold-off.
	always @(posedge clk or negedge arst_n) begin : receiver
		int     hold_left;
		blend_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected pixel, expected none, actual %h %h %h eof %b",
						$time, out_red, out_green, out_blue, end_of_frame);
					errors++;
				end else begin
					want = expected_pixels.pop_front();
					compare_field("red", want.red, out_red);
					compare_field("green", want.green, out_green);
					compare_field("blue", want.blue, out_blue);
					compare_field("end_of_frame", CH_W'(want.eof), CH_W'(end_of_frame));
				end
			end
			if (holdoff_req)
				hold_left = HOLD_LEN;
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// Watchdog: count cycles in which no beat moves on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int unsigned      beats;
		int unsigned      total;
		int unsigned      frame_no;
		logic [CFG_W-1:0] w_cfg;
		logic [CFG_W-1:0] h_cfg;
		logic [CFG_W-1:0] last_w;
		logic [CFG_W-1:0] last_h;
		bit               hold;
		bit               new_cfg;

		// Directed: stray flush straight out of reset.
		add_beat(MODE_FLUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF);

		// Single-row frame with both sizes written below range (used as 2 x 1):
		// every result comes from a flush, left and right only.
		add_cfg(REG_FRAME_WIDTH, '0);
		add_cfg(REG_FRAME_HEIGHT, '0);
		add_pace(0);
		add_beat(MODE_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_beat(MODE_PIXEL, 16'h0000, 16'h0000, 16'h0000);
		add_beat(MODE_PIXEL, 16'h5A5A, 16'hA5A5, 16'h0001);  // dropped, drain pending
		add_beat(MODE_FLUSH, 16'h0000, 16'h0000, 16'h0000);
		add_beat(MODE_FLUSH, 16'hFFFF, 16'h0000, 16'hFFFF);
		add_beat(MODE_FLUSH, 16'h1234, 16'h5678, 16'h9ABC);  // nothing pending

		// 3 x 3 frame: corners, edges and one pixel with all four neighbors.
		add_cfg(REG_FRAME_WIDTH, 11'd3);
		add_cfg(REG_FRAME_HEIGHT, 11'd3);
		add_beat(MODE_PIXEL, 16'hFFFF, 16'h0000, 16'hFFFF);
		add_beat(MODE_PIXEL, 16'h0000, 16'hFFFF, 16'h0000);
		add_beat(MODE_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_beat(MODE_PIXEL, 16'h8001, 16'h7FFE, 16'h0001);
		add_beat(MODE_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_beat(MODE_PIXEL, 16'h0000, 16'h0000, 16'h0000);
		add_beat(MODE_PIXEL, 16'h0003, 16'hFFFE, 16'h1234);
		add_beat(MODE_PIXEL, 16'h0000, 16'h0000, 16'h0000);
		add_beat(MODE_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_beat(MODE_FLUSH, 16'h0000, 16'h0000, 16'h0000);
		add_beat(MODE_FLUSH, 16'h0000, 16'h0000, 16'h0000);
		add_beat(MODE_FLUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF);

		// Random small frames, with one row at the widest size as frame WIDE_FRAME.
		total = 0;
		frame_no = 0;
		last_w = 11'd3;
		last_h = 11'd3;
		while (total < ITEMS) begin
			if (frame_no == WIDE_FRAME) begin
				// widest row: 2047 clamps to full width, single row
				w_cfg = 11'd2047;
				h_cfg = 11'd1;
				new_cfg = 1'b1;
				hold = 1'b0;
			end else begin
				hold = (frame_no % 15) == 2;
				new_cfg = frame_no < 3 || frame_no == WIDE_FRAME + 1 || hold
					|| $urandom_range(0, 2) != 0;
				if (!new_cfg) begin
					// keep the sizes already in the registers
					w_cfg = last_w;
					h_cfg = last_h;
				end else begin
					if (hold)
						// short rows, so results back up before the hold-off ends
						w_cfg = CFG_W'($urandom_range(2, 8));
					else if ($urandom_range(0, 9) == 0)
						w_cfg = CFG_W'($urandom_range(0, 1));
					else if ($urandom_range(0, 5) == 0)
						w_cfg = CFG_W'($urandom_range(13, 64));
					else
						w_cfg = CFG_W'($urandom_range(2, 12));
					h_cfg = hold ? 11'd4 : CFG_W'($urandom_range(0, 6));
				end
			end
			add_frame(w_cfg, h_cfg, new_cfg, frame_no, hold, beats);
			last_w = w_cfg;
			last_h = h_cfg;
			total += beats;
			frame_no++;
		end

		repeat (2) @(posedge clk);
		#1 arst_n = 1'b1;

		while ((plan_busy || expected_pixels.size() != 0) && quiet_cycles < QUIET_MAX)
			@(posedge clk);
		if (quiet_cycles >= QUIET_MAX) begin
			$display("%0t: timeout, %0d pixels still expected", $time, expected_pixels.size());
			$display("Mismatches found");
		end else begin
			// Watch a little longer for results nobody asked for.
			repeat (TAIL) @(posedge clk);
			if (errors == 0)
				$display("No mismatches found");
			else
				$display("Mismatches found");
		end
		$finish;
	end

endmodule
